### rtl/assert_macros.svh
//------------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands. Each use expects clk and rst in scope.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_HOLDS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its trigger.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/srsw_pkg.sv
//------------------------------------------------------------------------------
// srsw_pkg
// Widths, request codes and the controller command bundle of the
// selective-repeat sender window.
//------------------------------------------------------------------------------
package srsw_pkg;

  localparam int SEQ_BITS     = 3;
  localparam int PAYLOAD_BITS = 32;
  localparam int SEQ_SPACE    = 1 << SEQ_BITS;
  localparam int HALF_SPACE   = 1 << (SEQ_BITS - 1);
  localparam int CFG_BITS     = 3;
  localparam int WIN_BITS     = (CFG_BITS > SEQ_BITS) ? CFG_BITS : SEQ_BITS;
  localparam int REQ_BITS     = 2;

  localparam logic [CFG_BITS-1:0] WINDOW_RESET = CFG_BITS'(4);

  typedef logic [REQ_BITS-1:0] req_code_t;

  localparam req_code_t REQ_SEND    = 2'd0;
  localparam req_code_t REQ_ACK     = 2'd1;
  localparam req_code_t REQ_TIMEOUT = 2'd2;

  // capture: latch the accepted item and read its buffered payload
  // commit:  update the window and load the result register
  typedef struct packed {
    logic capture;
    logic commit;
  } srsw_cmd_t;

endpackage

### rtl/srsw_ctrl.sv
//------------------------------------------------------------------------------
// srsw_ctrl
// Handshake controller: accept one item, execute it, hand the result over.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module srsw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output srsw_pkg::srsw_cmd_t cmd
);
  import srsw_pkg::*;

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;

  always_comb begin
    cmd.capture = in_valid && in_ready;
    cmd.commit  = (state == EXEC) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd.capture) begin
            state    <= EXEC;
            in_ready <= 1'b0;
          end
          if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        EXEC: begin
          if (cmd.commit) begin
            state     <= IDLE;
            in_ready  <= 1'b1;
            out_valid <= 1'b1;
          end
        end
        default: begin
          state    <= IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

  `ASSERT_SAME(a_ready_only_idle, in_ready, state == IDLE, "ready outside idle")
  `ASSERT_NEXT(a_capture_exec, cmd.capture, (state == EXEC) && !in_ready, "capture lost")
  `ASSERT_NEXT(a_valid_from_commit, !out_valid && !cmd.commit, !out_valid, "spurious result")

endmodule

### rtl/srsw_dp.sv
//------------------------------------------------------------------------------
// srsw_dp
// Window datapath: sequence state, acknowledged marks, payload buffer and
// result register.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module srsw_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  srsw_pkg::srsw_cmd_t                 cmd,
  input  logic                                cfg_we,
  input  logic [srsw_pkg::CFG_BITS-1:0]       cfg_data,
  input  logic [srsw_pkg::REQ_BITS-1:0]       req_type,
  input  logic [srsw_pkg::PAYLOAD_BITS-1:0]   send_payload,
  input  logic [srsw_pkg::SEQ_BITS-1:0]       ack_number,
  input  logic                                ack_intact,
  input  logic [srsw_pkg::SEQ_BITS-1:0]       timeout_seq,
  output logic                                send_accepted,
  output logic                                tx_valid,
  output logic [srsw_pkg::SEQ_BITS-1:0]       tx_seq,
  output logic [srsw_pkg::PAYLOAD_BITS-1:0]   tx_payload,
  output logic                                timer_start,
  output logic                                timer_stop,
  output logic [srsw_pkg::SEQ_BITS-1:0]       timer_seq,
  output logic [srsw_pkg::SEQ_BITS-1:0]       window_base,
  output logic [srsw_pkg::SEQ_BITS-1:0]       next_seq_out
);
  import srsw_pkg::*;

  // window state
  logic [CFG_BITS-1:0]     window_size;
  logic [SEQ_BITS-1:0]     base_seq;
  logic [SEQ_BITS-1:0]     next_seq;
  logic [SEQ_SPACE-1:0]    acked_marks;
  logic [PAYLOAD_BITS-1:0] sent_buffer [SEQ_SPACE];

  // captured item
  req_code_t               req_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [SEQ_BITS-1:0]     ack_q;
  logic                    intact_q;
  logic [SEQ_BITS-1:0]     tseq_q;
  logic [PAYLOAD_BITS-1:0] rd_q;

  // execute-cycle logic
  logic [WIN_BITS-1:0]     win_raw;
  logic [WIN_BITS-1:0]     eff_win;
  logic [SEQ_BITS-1:0]     occ;
  logic [SEQ_BITS-1:0]     ack_dist;
  logic [SEQ_BITS-1:0]     tseq_dist;
  logic                    send_ok;
  logic                    ack_ok;
  logic                    tmo_ok;
  logic                    slide;
  logic [SEQ_SPACE-1:0]    marks_set;
  logic [SEQ_SPACE-1:0]    marks_rot;
  logic [SEQ_SPACE-1:0]    marks_next;
  logic [SEQ_BITS:0]       run_len;
  logic                    run_open;
  logic [SEQ_BITS-1:0]     base_next;
  logic [SEQ_BITS-1:0]     pos_dist;

  always_comb begin
    win_raw = WIN_BITS'(window_size);
    if (win_raw == '0) begin
      eff_win = WIN_BITS'(1);
    end else if (win_raw > WIN_BITS'(HALF_SPACE)) begin
      eff_win = WIN_BITS'(HALF_SPACE);
    end else begin
      eff_win = win_raw;
    end
  end

  assign occ       = next_seq - base_seq;
  assign ack_dist  = ack_q - base_seq;
  assign tseq_dist = tseq_q - base_seq;

  always_comb begin
    send_ok = 1'b0;
    ack_ok  = 1'b0;
    tmo_ok  = 1'b0;
    unique case (req_q)
      REQ_SEND:    send_ok = WIN_BITS'(occ) < eff_win;
      REQ_ACK:     ack_ok  = intact_q && (ack_dist < occ);
      REQ_TIMEOUT: tmo_ok  = (tseq_dist < occ) && !acked_marks[tseq_q];
      default: begin
        send_ok = 1'b0;
      end
    endcase
  end

  // Mark the acknowledged entry, then slide the base past the run of marks.
  always_comb begin
    marks_set = acked_marks;
    if (ack_ok) begin
      marks_set[ack_q] = 1'b1;
    end
    slide = ack_ok && (ack_q == base_seq);

    for (int i = 0; i < SEQ_SPACE; i++) begin
      marks_rot[i] = marks_set[SEQ_BITS'(base_seq + SEQ_BITS'(i))];
    end

    run_len  = '0;
    run_open = 1'b1;
    for (int i = 0; i < SEQ_SPACE; i++) begin
      if (run_open && marks_rot[i]) begin
        run_len = run_len + 1'b1;
      end else begin
        run_open = 1'b0;
      end
    end

    for (int j = 0; j < SEQ_SPACE; j++) begin
      pos_dist = SEQ_BITS'(j) - base_seq;
      if (slide && ({1'b0, pos_dist} < run_len)) begin
        marks_next[j] = 1'b0;
      end else begin
        marks_next[j] = marks_set[j];
      end
    end

    base_next = slide ? base_seq + run_len[SEQ_BITS-1:0] : base_seq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
      base_seq    <= '0;
      next_seq    <= '0;
      acked_marks <= '0;
    end else begin
      if (cfg_we) begin
        window_size <= cfg_data;
      end
      if (cmd.commit) begin
        base_seq    <= base_next;
        acked_marks <= marks_next;
        if (send_ok) begin
          next_seq <= next_seq + 1'b1;
        end
      end
    end
  end

  // payload buffer: read at capture, write on an accepted send
  always_ff @(posedge clk) begin
    if (cmd.commit && send_ok) begin
      sent_buffer[next_seq] <= pay_q;
    end
    if (cmd.capture) begin
      rd_q <= sent_buffer[timeout_seq];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q    <= req_type;
      pay_q    <= send_payload;
      ack_q    <= ack_number;
      intact_q <= ack_intact;
      tseq_q   <= timeout_seq;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      send_accepted <= send_ok;
      tx_valid      <= send_ok || tmo_ok;
      timer_start   <= send_ok || tmo_ok;
      timer_stop    <= ack_ok;
      window_base   <= base_next;
      next_seq_out  <= send_ok ? next_seq + 1'b1 : next_seq;
      if (send_ok) begin
        tx_seq     <= next_seq;
        tx_payload <= pay_q;
        timer_seq  <= next_seq;
      end else if (tmo_ok) begin
        tx_seq     <= tseq_q;
        tx_payload <= rd_q;
        timer_seq  <= tseq_q;
      end else if (ack_ok) begin
        tx_seq     <= '0;
        tx_payload <= '0;
        timer_seq  <= ack_q;
      end else begin
        tx_seq     <= '0;
        tx_payload <= '0;
        timer_seq  <= '0;
      end
    end
  end

  `ASSERT_HOLDS(a_occupancy, WIN_BITS'(occ) <= WIN_BITS'(HALF_SPACE), "window overrun")
  `ASSERT_HOLDS(a_base_unmarked, !acked_marks[base_seq], "base left marked")
  `ASSERT_NEXT(a_next_advance, cmd.commit && send_ok,
               next_seq == SEQ_BITS'($past(next_seq) + 1'b1), "next not advanced")

endmodule

### rtl/selective_repeat_sender_window_core.sv
//------------------------------------------------------------------------------
// selective_repeat_sender_window_core
// Sender side of a selective-repeat ARQ window.
//------------------------------------------------------------------------------
// Each accepted item yields exactly one result item. The accept edge latches
// the request and reads the payload buffer; the commit edge, once the result
// register is free, applies the request to the window and loads the result
// register. A new item is taken in the cycle after the commit, not before the
// last one is through; a result that is not taken holds the block in its
// execute state. The single buffer read port, addressed at accept time, serves
// the accept step; the mark update and base slide over the acknowledged bitmap
// serve the commit step. window_size is to be written through cfg_we/cfg_data
// only while idle; the block itself does not enforce this. 0 acts as 1, and
// values above half the sequence space act as half of it.
//------------------------------------------------------------------------------
module selective_repeat_sender_window_core (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [srsw_pkg::CFG_BITS-1:0]       cfg_data,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [srsw_pkg::REQ_BITS-1:0]       req_type,
  input  logic [srsw_pkg::PAYLOAD_BITS-1:0]   send_payload,
  input  logic [srsw_pkg::SEQ_BITS-1:0]       ack_number,
  input  logic                                ack_intact,
  input  logic [srsw_pkg::SEQ_BITS-1:0]       timeout_seq,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                send_accepted,
  output logic                                tx_valid,
  output logic [srsw_pkg::SEQ_BITS-1:0]       tx_seq,
  output logic [srsw_pkg::PAYLOAD_BITS-1:0]   tx_payload,
  output logic                                timer_start,
  output logic                                timer_stop,
  output logic [srsw_pkg::SEQ_BITS-1:0]       timer_seq,
  output logic [srsw_pkg::SEQ_BITS-1:0]       window_base,
  output logic [srsw_pkg::SEQ_BITS-1:0]       next_seq_out
);
  import srsw_pkg::*;

  srsw_cmd_t cmd;

  // Sequence the handshakes: capture on accept, commit when the result
  // register is free, release the result on out_ready.
  srsw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Hold the window state, payload buffer and result register; execute the
  // send, acknowledge and timeout requests on commit.
  srsw_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .req_type      (req_type),
    .send_payload  (send_payload),
    .ack_number    (ack_number),
    .ack_intact    (ack_intact),
    .timeout_seq   (timeout_seq),
    .send_accepted (send_accepted),
    .tx_valid      (tx_valid),
    .tx_seq        (tx_seq),
    .tx_payload    (tx_payload),
    .timer_start   (timer_start),
    .timer_stop    (timer_stop),
    .timer_seq     (timer_seq),
    .window_base   (window_base),
    .next_seq_out  (next_seq_out)
  );

endmodule
